// ===== sv/xoshiro256starstar_generator_core_assert.svh =====
// Assertion macros shared by the generator modules.
// Each macro takes a label, the clock, the active-low reset and two expressions.
`ifndef XOSHIRO256STARSTAR_GENERATOR_CORE_ASSERT_SVH
`define XOSHIRO256STARSTAR_GENERATOR_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define XSR_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define XSR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

// ===== sv/xsr_pkg.sv =====
package xsr_pkg;

	// Operation codes of the request word.
	localparam logic OP_GENERATE = 1'b0;
	localparam logic OP_SEED     = 1'b1;

	// Splitmix64 constants.
	localparam logic [63:0] GOLDEN_STEP = 64'h9e3779b97f4a7c15;
	localparam logic [63:0] MIX_MUL_A   = 64'hbf58476d1ce4e5b9;
	localparam logic [63:0] MIX_MUL_B   = 64'h94d049bb133111eb;

	// Generator state after reset.
	localparam logic [63:0] WORD0_RESET = 64'h12345678deadbeef;
	localparam logic [63:0] WORD1_RESET = 64'hfeedface01020304;
	localparam logic [63:0] WORD2_RESET = 64'habcdef0011223344;
	localparam logic [63:0] WORD3_RESET = 64'h99887766aabbccdd;

	localparam int NUM_WORDS   = 4;
	localparam int QUEUE_DEPTH = 2;

	// Request and result words.
	typedef struct packed {
		logic        operation;
		logic [63:0] seed_value;
	} in_word_t;

	typedef struct packed {
		logic [63:0] random_value;
		logic [52:0] unit_fraction;
	} out_word_t;

	// Classified command passed from the front end to the engine.
	typedef enum logic {
		CMD_GENERATE,
		CMD_SEED
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t   kind;
		logic [63:0] seed;
	} cmd_t;

	// Engine sequencer states.
	typedef enum logic [2:0] {
		ENG_IDLE,
		ENG_PREP,
		ENG_MUL_A,
		ENG_XS_B,
		ENG_MUL_B,
		ENG_STORE
	} eng_state_t;

	// Partial-product steps of the 64-bit constant multiply.
	typedef enum logic [1:0] {
		PH_LO_LO,
		PH_LO_HI,
		PH_HI_LO
	} mul_phase_t;

endpackage

// ===== sv/xsr_stream_if.sv =====
interface xsr_stream_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ===== sv/xsr_front.sv =====
module xsr_front (
	input  logic          clk,
	input  logic          arst_n,
	xsr_stream_if.sink    request,
	output xsr_pkg::cmd_t push_cmd,
	output logic          push_valid,
	input  logic          push_ready
);

	logic          valid_q;
	xsr_pkg::cmd_t cmd_q;
	xsr_pkg::cmd_t cmd_d;
	logic          accept;

	// Decode the operation of the incoming word.
	always_comb begin
		cmd_d.seed = request.payload.seed_value;
		unique case (request.payload.operation)
			xsr_pkg::OP_SEED:     cmd_d.kind = xsr_pkg::CMD_SEED;
			xsr_pkg::OP_GENERATE: cmd_d.kind = xsr_pkg::CMD_GENERATE;
			default:              cmd_d.kind = xsr_pkg::CMD_GENERATE;
		endcase
	end

	// The holding register frees up whenever the queue takes its word.
	assign request.ready = !valid_q || push_ready;
	assign accept        = request.valid && request.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (accept) begin
			valid_q <= 1'b1;
		end else if (push_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= cmd_d;
		end
	end

	assign push_cmd   = cmd_q;
	assign push_valid = valid_q;

endmodule

// ===== sv/xsr_queue.sv =====
`include "xoshiro256starstar_generator_core_assert.svh"

module xsr_queue #(
	parameter int DEPTH = xsr_pkg::QUEUE_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  xsr_pkg::cmd_t push_cmd,
	input  logic          push_valid,
	output logic          push_ready,
	output xsr_pkg::cmd_t pop_cmd,
	output logic          pop_valid,
	input  logic          pop_ready
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	xsr_pkg::cmd_t    entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push;
	logic             pop;

	assign push_ready = (count_q != CNT_FULL);
	assign pop_valid  = (count_q != '0);
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_cmd    = entry_q[rd_ptr_q];

	// Pointers wrap at the queue depth; the count tracks occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	// Occupancy never passes the depth, and a full queue has its write pointer
	// back at its read pointer.
	`XSR_ASSERT_IMPLIES(a_count_bound, clk, arst_n, 1'b1, count_q <= CNT_FULL)
	`XSR_ASSERT_IMPLIES(a_full_ptrs, clk, arst_n, count_q == CNT_FULL, wr_ptr_q == rd_ptr_q)

endmodule

// ===== sv/xsr_engine.sv =====
`include "xoshiro256starstar_generator_core_assert.svh"

module xsr_engine (
	input  logic          clk,
	input  logic          arst_n,
	input  xsr_pkg::cmd_t pop_cmd,
	input  logic          pop_valid,
	output logic          pop_ready,
	xsr_stream_if.source  result
);

	localparam logic [1:0] WORD_LAST = 2'(xsr_pkg::NUM_WORDS - 1);

	xsr_pkg::eng_state_t state_q;
	xsr_pkg::eng_state_t state_d;
	xsr_pkg::mul_phase_t phase_q;

	logic [63:0] word_q [xsr_pkg::NUM_WORDS];
	logic [1:0]  word_idx_q;
	logic [63:0] acc_q;
	logic [63:0] mop_q;
	logic [63:0] prod_q;

	logic        s1_valid_q;
	logic [63:0] p5_s1;
	logic        out_valid_q;
	logic [63:0] value_q;

	logic        gen_pop;
	logic        seed_pop;
	logic        mul_active;
	logic        adv_out;
	logic        s1_free;
	logic        seed_last;
	logic [63:0] mul_const;
	logic [31:0] mul_x;
	logic [31:0] mul_y;
	logic [63:0] mul_p;
	logic [63:0] rot_p5;
	logic [63:0] t_shift;
	logic [63:0] n0;
	logic [63:0] n1;
	logic [63:0] n2;
	logic [63:0] n3;

	// Scrambler pipeline flow control.
	assign adv_out = !out_valid_q || result.ready;
	assign s1_free = !s1_valid_q || adv_out;

	// Sequencer next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			xsr_pkg::ENG_IDLE: begin
				if (seed_pop) begin
					state_d = xsr_pkg::ENG_PREP;
				end
			end
			xsr_pkg::ENG_PREP: state_d = xsr_pkg::ENG_MUL_A;
			xsr_pkg::ENG_MUL_A: begin
				if (phase_q == xsr_pkg::PH_HI_LO) begin
					state_d = xsr_pkg::ENG_XS_B;
				end
			end
			xsr_pkg::ENG_XS_B: state_d = xsr_pkg::ENG_MUL_B;
			xsr_pkg::ENG_MUL_B: begin
				if (phase_q == xsr_pkg::PH_HI_LO) begin
					state_d = xsr_pkg::ENG_STORE;
				end
			end
			xsr_pkg::ENG_STORE: begin
				state_d = (word_idx_q == WORD_LAST) ? xsr_pkg::ENG_IDLE : xsr_pkg::ENG_PREP;
			end
			default: state_d = xsr_pkg::ENG_IDLE;
		endcase
	end

	// Sequencer outputs: queue pops and multiplier control.
	always_comb begin
		gen_pop    = 1'b0;
		seed_pop   = 1'b0;
		mul_active = 1'b0;
		mul_const  = xsr_pkg::MIX_MUL_A;
		unique case (state_q)
			xsr_pkg::ENG_IDLE: begin
				gen_pop  = pop_valid && (pop_cmd.kind == xsr_pkg::CMD_GENERATE) && s1_free;
				seed_pop = pop_valid && (pop_cmd.kind == xsr_pkg::CMD_SEED);
			end
			xsr_pkg::ENG_MUL_A: begin
				mul_active = 1'b1;
			end
			xsr_pkg::ENG_MUL_B: begin
				mul_active = 1'b1;
				mul_const  = xsr_pkg::MIX_MUL_B;
			end
			default: begin
				mul_active = 1'b0;
			end
		endcase
	end

	assign pop_ready = gen_pop || seed_pop;

	// One 32x32 partial product per cycle; only the low 64 bits are kept.
	always_comb begin
		unique case (phase_q)
			xsr_pkg::PH_LO_LO: begin
				mul_x = mop_q[31:0];
				mul_y = mul_const[31:0];
			end
			xsr_pkg::PH_LO_HI: begin
				mul_x = mop_q[31:0];
				mul_y = mul_const[63:32];
			end
			xsr_pkg::PH_HI_LO: begin
				mul_x = mop_q[63:32];
				mul_y = mul_const[31:0];
			end
			default: begin
				mul_x = mop_q[31:0];
				mul_y = mul_const[31:0];
			end
		endcase
		mul_p = 64'(mul_x) * 64'(mul_y);
	end

	// Next xoshiro state: xor network, shift by 17 and rotate by 45.
	always_comb begin
		t_shift = word_q[1] << 17;
		n2      = word_q[2] ^ word_q[0];
		n3      = word_q[3] ^ word_q[1];
		n1      = word_q[1] ^ n2;
		n0      = word_q[0] ^ n3;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= xsr_pkg::ENG_IDLE;
			phase_q     <= xsr_pkg::PH_LO_LO;
			word_idx_q  <= '0;
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
			word_q[0]   <= xsr_pkg::WORD0_RESET;
			word_q[1]   <= xsr_pkg::WORD1_RESET;
			word_q[2]   <= xsr_pkg::WORD2_RESET;
			word_q[3]   <= xsr_pkg::WORD3_RESET;
		end else begin
			state_q <= state_d;

			// Partial-product step counter.
			if (mul_active) begin
				unique case (phase_q)
					xsr_pkg::PH_LO_LO: phase_q <= xsr_pkg::PH_LO_HI;
					xsr_pkg::PH_LO_HI: phase_q <= xsr_pkg::PH_HI_LO;
					default:           phase_q <= xsr_pkg::PH_LO_LO;
				endcase
			end else begin
				phase_q <= xsr_pkg::PH_LO_LO;
			end

			if (seed_pop) begin
				word_idx_q <= '0;
			end else if (state_q == xsr_pkg::ENG_STORE) begin
				word_idx_q <= word_idx_q + 1'b1;
			end

			// State words advance on a generate and are rewritten by seeding.
			if (gen_pop) begin
				word_q[0] <= n0;
				word_q[1] <= n1;
				word_q[2] <= n2 ^ t_shift;
				word_q[3] <= {n3[18:0], n3[63:19]};
			end else if (state_q == xsr_pkg::ENG_STORE) begin
				word_q[word_idx_q] <= prod_q ^ (prod_q >> 31);
			end

			if (gen_pop) begin
				s1_valid_q <= 1'b1;
			end else if (adv_out) begin
				s1_valid_q <= 1'b0;
			end

			if (adv_out) begin
				out_valid_q <= s1_valid_q;
			end
		end
	end

	// Splitmix datapath registers.
	always_ff @(posedge clk) begin
		if (seed_pop) begin
			acc_q <= pop_cmd.seed + xsr_pkg::GOLDEN_STEP;
		end else if (state_q == xsr_pkg::ENG_STORE) begin
			acc_q <= acc_q + xsr_pkg::GOLDEN_STEP;
		end

		if (state_q == xsr_pkg::ENG_PREP) begin
			mop_q <= acc_q ^ (acc_q >> 30);
		end else if (state_q == xsr_pkg::ENG_XS_B) begin
			mop_q <= prod_q ^ (prod_q >> 27);
		end

		if (mul_active) begin
			if (phase_q == xsr_pkg::PH_LO_LO) begin
				prod_q <= mul_p;
			end else begin
				prod_q <= {prod_q[63:32] + mul_p[31:0], prod_q[31:0]};
			end
		end
	end

	// Scrambler: w1*5 in the first stage, rotate by 7 and times 9 in the second.
	assign rot_p5 = {p5_s1[56:0], p5_s1[63:57]};

	always_ff @(posedge clk) begin
		if (gen_pop) begin
			p5_s1 <= word_q[1] + (word_q[1] << 2);
		end
		if (adv_out && s1_valid_q) begin
			value_q <= rot_p5 + (rot_p5 << 3);
		end
	end

	assign result.valid                 = out_valid_q;
	assign result.payload.random_value  = value_q;
	assign result.payload.unit_fraction = value_q[63:11];

	// The store of the last state word of a seed load.
	assign seed_last = (state_q == xsr_pkg::ENG_STORE) && (word_idx_q == WORD_LAST);

	// Pops happen only from idle, a seed load ends after the last word, and a
	// generate always fills the scrambler stage.
	`XSR_ASSERT_IMPLIES(a_pop_idle, clk, arst_n, pop_ready, state_q == xsr_pkg::ENG_IDLE)
	`XSR_ASSERT_NEXT(a_seed_done, clk, arst_n, seed_last, state_q == xsr_pkg::ENG_IDLE)
	`XSR_ASSERT_NEXT(a_gen_fill, clk, arst_n, gen_pop, s1_valid_q)

endmodule

// ===== sv/xoshiro256starstar_generator_core.sv =====
// Generate word: one result per cycle sustained while no seed loads and result is ready.
// Seed word: no result; the splitmix64 sequencer takes each state word through prep,
// mul, xor-shift, mul, store (shared 32x32 multiplier, three partial products per mul).
// Words behind a seed wait for it; with the default queue depth, up to three of them
// (holding register plus queue) are accepted meanwhile.
// Reset (arst_n low, asynchronous) loads the fixed state words and empties all stages.
module xoshiro256starstar_generator_core #(
	parameter int QUEUE_DEPTH = xsr_pkg::QUEUE_DEPTH
) (
	input  logic         clk,
	input  logic         arst_n,
	xsr_stream_if.sink   request,
	xsr_stream_if.source result
);

	xsr_pkg::cmd_t push_cmd;
	logic          push_valid;
	logic          push_ready;
	xsr_pkg::cmd_t pop_cmd;
	logic          pop_valid;
	logic          pop_ready;

	// Front end: takes request words and classifies them.
	xsr_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.request    (request),
		.push_cmd   (push_cmd),
		.push_valid (push_valid),
		.push_ready (push_ready)
	);

	// Command queue between the front end and the engine.
	xsr_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_cmd   (push_cmd),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.pop_cmd    (pop_cmd),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready)
	);

	// Engine: state update, scrambler and seeding sequencer.
	xsr_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_cmd   (pop_cmd),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.result    (result)
	);

endmodule

// ===== tb/sv/tb_xoshiro256starstar_generator_core.sv =====
module tb_xoshiro256starstar_generator_core;
	timeunit 1ns;
	timeprecision 1ps;

	import xsr_pkg::*;

	// Tracks the generator state and the draws that the block still owes.
	class draw_tracker;
		logic [63:0] gen_word [NUM_WORDS];
		out_word_t   pending_draws [$];
		int unsigned mismatch_count;

		function new();
			gen_word[0] = WORD0_RESET;
			gen_word[1] = WORD1_RESET;
			gen_word[2] = WORD2_RESET;
			gen_word[3] = WORD3_RESET;
			mismatch_count = 0;
		endfunction

		function logic [63:0] rotl(logic [63:0] v, int unsigned amt);
			return (v << amt) | (v >> (64 - amt));
		endfunction

		// Splitmix64 finalizer; every product wraps at 64 bits.
		function logic [63:0] splitmix(logic [63:0] z);
			logic [63:0] m;
			m = z ^ (z >> 30);
			m = m * MIX_MUL_A;
			m = m ^ (m >> 27);
			m = m * MIX_MUL_B;
			return m ^ (m >> 31);
		endfunction

		// A seed word reloads the state; a generate word owes one draw and advances it.
		function void note_request(in_word_t w);
			logic [63:0] acc;
			logic [63:0] scrambled;
			logic [63:0] shifted;
			out_word_t   draw;
			if (w.operation == OP_SEED) begin
				acc = w.seed_value;
				for (int i = 0; i < NUM_WORDS; i++) begin
					acc = acc + GOLDEN_STEP;
					gen_word[i] = splitmix(acc);
				end
			end else begin
				scrambled = gen_word[1] * 64'd5;
				scrambled = rotl(scrambled, 7) * 64'd9;
				shifted = gen_word[1] << 17;
				gen_word[2] = gen_word[2] ^ gen_word[0];
				gen_word[3] = gen_word[3] ^ gen_word[1];
				gen_word[1] = gen_word[1] ^ gen_word[2];
				gen_word[0] = gen_word[0] ^ gen_word[3];
				gen_word[2] = gen_word[2] ^ shifted;
				gen_word[3] = rotl(gen_word[3], 45);
				draw.random_value = scrambled;
				draw.unit_fraction = scrambled[63:11];
				pending_draws.push_back(draw);
			end
		endfunction

		// Compares a delivered draw against the oldest one owed.
		function void check_draw(out_word_t got);
			out_word_t want;
			if (pending_draws.size() == 0) begin
				$error("unexpected result word: random_value %h", got.random_value);
				mismatch_count++;
				return;
			end
			want = pending_draws.pop_front();
			if (got.random_value !== want.random_value) begin
				$error("random_value mismatch: expected %h, actual %h",
					want.random_value, got.random_value);
				mismatch_count++;
			end
			if (got.unit_fraction !== want.unit_fraction) begin
				$error("unit_fraction mismatch: expected %h, actual %h",
					want.unit_fraction, got.unit_fraction);
				mismatch_count++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	xsr_stream_if #(.payload_t(in_word_t))  request_ch ();
	xsr_stream_if #(.payload_t(out_word_t)) result_ch ();

	draw_tracker tracker = new();

	int unsigned send_idle_pct;
	int unsigned recv_idle_pct;
	int unsigned hold_request;
	int unsigned hold_left;
	int unsigned stall_left;

	xoshiro256starstar_generator_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.request(request_ch),
		.result (result_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Idle length: mostly none or short, now and then a long one.
	function automatic int unsigned idle_len(int unsigned pct);
		if ($urandom_range(99) >= pct)
			return 0;
		if ($urandom_range(9) != 0)
			return $urandom_range(1, 3);
		return $urandom_range(15, 50);
	endfunction

	// Seeds lean on the extremes now and then, including one that zeroes word 0.
	function automatic logic [63:0] pick_seed();
		case ($urandom_range(15))
			0: return 64'h0;
			1: return '1;
			2: return (~GOLDEN_STEP) + 64'd1;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	// Offer one word, after an optional idle gap, and wait until it is taken.
	task automatic send_word(input logic op, input logic [63:0] seed);
		int unsigned gap;
		gap = idle_len(send_idle_pct);
		@(negedge clk);
		if (gap != 0) begin
			request_ch.valid <= 1'b0;
			request_ch.payload <= '{operation: 1'($urandom_range(1)),
				seed_value: {$urandom, $urandom}};
			repeat (gap) @(negedge clk);
		end
		request_ch.valid <= 1'b1;
		request_ch.payload <= '{operation: op, seed_value: seed};
		do @(posedge clk); while (!request_ch.ready);
	endtask

	// Stop offering and wait for every owed draw.
	task automatic drain();
		@(negedge clk);
		request_ch.valid <= 1'b0;
		while (tracker.pending_draws.size() != 0)
			@(posedge clk);
	endtask

	// Result side: random stalls, plus one long hold-off on request.
	initial begin
		result_ch.ready = 1'b0;
		hold_left = 0;
		stall_left = 0;
		forever begin
			@(negedge clk);
			if (hold_left == 0 && hold_request != 0) begin
				hold_left = hold_request;
				hold_request = 0;
			end
			if (hold_left != 0) begin
				hold_left--;
				result_ch.ready <= 1'b0;
			end else if (stall_left != 0) begin
				stall_left--;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= 1'b1;
				stall_left = idle_len(recv_idle_pct);
			end
		end
	end

	// Every accepted word updates the prediction; every delivered word is checked.
	always @(posedge clk) begin
		if (arst_n && result_ch.valid && result_ch.ready)
			tracker.check_draw(result_ch.payload);
		if (arst_n && request_ch.valid && request_ch.ready)
			tracker.note_request(request_ch.payload);
	end

	initial begin
		int unsigned random_items;
		int unsigned run_len;
		bit          pressure_done;
		arst_n = 1'b0;
		request_ch.valid = 1'b0;
		request_ch.payload = '0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_request = 0;
		random_items = 0;
		pressure_done = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: draws from the reset state, ignored seed fields, extreme seeds,
		// a seed that zeroes word 0, and back-to-back seeds.
		send_word(OP_GENERATE, 64'h0);
		send_word(OP_GENERATE, 64'h0);
		send_word(OP_GENERATE, 64'h0);
		send_word(OP_GENERATE, '1);
		send_word(OP_SEED, 64'h0);
		send_word(OP_GENERATE, 64'h0);
		send_word(OP_GENERATE, 64'h0);
		send_word(OP_SEED, '1);
		send_word(OP_GENERATE, '1);
		send_word(OP_SEED, (~GOLDEN_STEP) + 64'd1);
		send_word(OP_GENERATE, 64'h0);
		send_word(OP_GENERATE, 64'h0);
		send_word(OP_SEED, 64'h8000000000000000);
		send_word(OP_SEED, 64'h1);
		send_word(OP_GENERATE, 64'h0);
		send_word(OP_SEED, 64'h5555555555555555);
		send_word(OP_GENERATE, 64'haaaaaaaaaaaaaaaa);
		drain();

		// Random: mostly a seed followed by a run of draws, some mixed noise.
		while (random_items < 1200) begin
			case ($urandom_range(3))
				0: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
				1: begin send_idle_pct = 15; recv_idle_pct = 15; end
				2: begin send_idle_pct = 50; recv_idle_pct = 40; end
				default: begin send_idle_pct = 0; recv_idle_pct = 60; end
			endcase
			if ($urandom_range(9) < 8) begin
				send_word(OP_SEED, pick_seed());
				run_len = $urandom_range(1, 30);
				repeat (run_len) send_word(OP_GENERATE, {$urandom, $urandom});
				random_items += run_len + 1;
			end else begin
				run_len = $urandom_range(1, 10);
				repeat (run_len) send_word(1'($urandom_range(1)), pick_seed());
				random_items += run_len;
			end

			// Once: hold the result side while words keep coming, then drain fully.
			if (!pressure_done && random_items >= 600) begin
				pressure_done = 1'b1;
				send_idle_pct = 0;
				hold_request = 300;
				repeat (40) send_word(OP_GENERATE, {$urandom, $urandom});
				random_items += 40;
				drain();
			end
		end

		drain();
		repeat (60) @(posedge clk);
		if (tracker.mismatch_count == 0)
			$display("tb_xoshiro256starstar_generator_core passed");
		else
			$display("tb_xoshiro256starstar_generator_core failed");
		$finish;
	end

	// Run limit.
	initial begin
		#20_000_000;
		$display("tb_xoshiro256starstar_generator_core failed");
		$finish;
	end

endmodule

// ===== xoshiro256starstar_generator_core.f =====
+incdir+sv
sv/xsr_pkg.sv
sv/xsr_stream_if.sv
sv/xsr_front.sv
sv/xsr_queue.sv
sv/xsr_engine.sv
sv/xoshiro256starstar_generator_core.sv
tb/sv/tb_xoshiro256starstar_generator_core.sv
